/* hw/rtl/cache_tags_bit_plru_defines.svh */
// Assertion macros shared by the tag store RTL.
`ifndef CACHE_TAGS_BIT_PLRU_DEFINES_SVH
`define CACHE_TAGS_BIT_PLRU_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset.
`define CBP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset.
`define CBP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define CBP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

/* hw/rtl/cbp_pkg.sv */
// Shared types and constants of the bit-PLRU cache tag store.
`default_nettype none

package cbp_pkg;

    // Fixed field widths of the streams and config port
    localparam int ADDR_W     = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_WAY_W  = 2;

    // Operation codes carried in tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_FILL   = 2'd1,
        MODE_INVAL  = 2'd2
    } mode_t;

    // Config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_SIZE_LOG2 = 2'd0,
        REG_SETS_LOG2       = 2'd1,
        REG_WAYS_USED       = 2'd2
    } cfg_reg_t;

    // Reset values of the config registers
    localparam logic [CFG_DATA_W-1:0] RST_BLOCK_SIZE_LOG2 = 3'd2;
    localparam logic [CFG_DATA_W-1:0] RST_SETS_LOG2       = 3'd4;
    localparam logic [CFG_DATA_W-1:0] RST_WAYS_USED       = 3'd4;

    // Result beat, hit in bit 0
    typedef struct packed {
        logic [OUT_WAY_W-1:0] way;
        logic                 hit;
    } res_t;

    // Top-level sequencer states
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/cbp_tag_ram.sv */
// Synchronous row memory: one write port, one registered read port.
`default_nettype none

module cbp_tag_ram #(
    parameter int DEPTH  = 16,
    parameter int IDX_W  = 4,
    parameter int DATA_W = 72
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [IDX_W-1:0]  waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [IDX_W-1:0]  raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/cbp_way_logic.sv */
// Way compare, victim pick and MRU-bit update for one set row.
`default_nettype none

module cbp_way_logic #(
    parameter int WAYS  = 4,
    parameter int TAG_W = 16,
    parameter int NW_W  = 3
) (
    input  wire logic [WAYS*(TAG_W+2)-1:0] row_in,
    input  wire cbp_pkg::mode_t            mode,
    input  wire logic [TAG_W-1:0]          tag,
    input  wire logic [NW_W-1:0]           nw,
    output logic      [WAYS*(TAG_W+2)-1:0] row_out,
    output cbp_pkg::res_t                  res
);

    localparam int EW    = TAG_W + 2;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [TAG_W-1:0] tags   [WAYS];
    logic [TAG_W-1:0] tags_n [WAYS];
    logic [WAYS-1:0]  valid, valid_n, mru, mru_n;
    logic [WAYS-1:0]  in_use, match, mru_free;
    logic [WAYS-1:0]  tgt_oh, mru_set, mru_touch;
    logic [WAY_W-1:0] hit_idx, free_idx, tgt_idx, res_idx;
    logic             any_hit, all_set, one_way, res_hit;
    logic [31:0]      res_idx32;

    // Unpack the row and compare every way in parallel
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            tags[i]     = row_in[i*EW +: TAG_W];
            valid[i]    = row_in[i*EW + TAG_W];
            mru[i]      = row_in[i*EW + TAG_W + 1];
            in_use[i]   = 32'(nw) > 32'(i);
            match[i]    = in_use[i] && valid[i] && (tags[i] == tag);
            mru_free[i] = in_use[i] && !mru[i];
        end
    end

    // First matching way and first way with a clear MRU bit
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = WAY_W'(i);
            end
            if (mru_free[i]) begin
                free_idx = WAY_W'(i);
            end
        end
    end

    assign any_hit = |match;
    assign tgt_idx = (mode == cbp_pkg::MODE_FILL) ? free_idx : hit_idx;
    assign one_way = (nw == NW_W'(1));

    // Touch: set the target bit, clear the rest once all used bits are set (all of them with one way)
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            tgt_oh[i] = (WAY_W'(i) == tgt_idx);
        end
        mru_set = mru | tgt_oh;
        all_set = &(mru_set | ~in_use);
        for (int i = 0; i < WAYS; i++) begin
            mru_touch[i] = (all_set && in_use[i] && (!tgt_oh[i] || one_way))
                           ? 1'b0 : mru_set[i];
        end
    end

    // Row update per operation
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            tags_n[i] = tags[i];
        end
        valid_n = valid;
        mru_n   = mru;
        res_hit = 1'b0;
        res_idx = '0;
        case (mode)
            cbp_pkg::MODE_LOOKUP: begin
                if (any_hit) begin
                    res_hit = 1'b1;
                    res_idx = hit_idx;
                    mru_n   = mru_touch;
                end
            end
            cbp_pkg::MODE_FILL: begin
                res_idx = free_idx;
                for (int i = 0; i < WAYS; i++) begin
                    if (tgt_oh[i]) begin
                        tags_n[i]  = tag;
                        valid_n[i] = 1'b1;
                    end
                end
                mru_n = mru_touch;
            end
            cbp_pkg::MODE_INVAL: begin
                if (any_hit) begin
                    res_hit = 1'b1;
                    res_idx = hit_idx;
                    for (int i = 0; i < WAYS; i++) begin
                        if (tgt_oh[i]) begin
                            valid_n[i] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                res_hit = 1'b0;
            end
        endcase
    end

    // Repack
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            row_out[i*EW +: TAG_W]  = tags_n[i];
            row_out[i*EW + TAG_W]   = valid_n[i];
            row_out[i*EW + TAG_W + 1] = mru_n[i];
        end
    end

    assign res_idx32 = 32'(res_idx);
    assign res.hit   = res_hit;
    assign res.way   = res_idx32[cbp_pkg::OUT_WAY_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/cache_tags_bit_plru.sv */
// Top level of the bit-PLRU cache tag store: config, pipeline, clear pass.
//
//  Channel  | Ports                       | Beat contents
//  ---------+-----------------------------+---------------------------------
//  input    | s_tvalid s_tready s_tdata   | tdata: phys_addr; tuser: mode
//  result   | m_tvalid m_tready m_tdata   | tdata: hit, way, zero pad
//  config   | cfg_we cfg_addr cfg_wdata   | register index, value
//
// One beat per cycle sustained while the result does not stall; the set row is read at
// the accepting edge, then compare and write-back run in the next stage, whose result sets m_tvalid.
// Back-to-back beats to the same set use the forwarded row, not the memory.
// After reset a clear pass zeroes every row of the set memory, with s_tready low.
// A stalled result holds the compare stage; input stalls only then and during the clear pass.
`default_nettype none
`include "cache_tags_bit_plru_defines.svh"

module cache_tags_bit_plru #(
    parameter int SETS      = 16,
    parameter int WAYS      = 4,
    parameter int ADDR_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // tdata: phys_addr[15:0]
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [cbp_pkg::ADDR_W-1:0]        s_tdata,
    // tuser: mode[1:0]
    input  wire logic [cbp_pkg::MODE_W-1:0]        s_tuser,
    // tdata: hit[0], way[2:1], zero[7:3]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [cbp_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [cbp_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [cbp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AW     = (ADDR_BITS < cbp_pkg::ADDR_W) ? ADDR_BITS : cbp_pkg::ADDR_W;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SL_MAX = $clog2(SETS + 1) - 1;
    localparam int NW_W   = $clog2(WAYS + 1);
    localparam int ROW_W  = WAYS * (AW + 2);

    // Config registers
    logic [cbp_pkg::CFG_DATA_W-1:0] blk_log2_reg, sets_log2_reg, ways_used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_log2_reg  <= cbp_pkg::RST_BLOCK_SIZE_LOG2;
            sets_log2_reg <= cbp_pkg::RST_SETS_LOG2;
            ways_used_reg <= cbp_pkg::RST_WAYS_USED;
        end else if (cfg_we) begin
            case (cbp_pkg::cfg_reg_t'(cfg_addr))
                cbp_pkg::REG_BLOCK_SIZE_LOG2: blk_log2_reg  <= cfg_wdata;
                cbp_pkg::REG_SETS_LOG2:       sets_log2_reg <= cfg_wdata;
                cbp_pkg::REG_WAYS_USED:       ways_used_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Effective set bits and way count
    logic [cbp_pkg::CFG_DATA_W-1:0] sl_eff;
    logic [NW_W-1:0]                nw;

    always_comb begin
        sl_eff = (32'(sets_log2_reg) > SL_MAX) ? cbp_pkg::CFG_DATA_W'(SL_MAX) : sets_log2_reg;
        if (ways_used_reg == '0) begin
            nw = NW_W'(1);
        end else if (32'(ways_used_reg) > WAYS) begin
            nw = NW_W'(WAYS);
        end else begin
            nw = NW_W'(ways_used_reg);
        end
    end

    // Address split: offset dropped, set index, tag
    logic [31:0]      blk32, set32, tag32;
    logic [SET_W-1:0] in_set;
    logic [AW-1:0]    in_tag;

    always_comb begin
        blk32  = 32'(s_tdata[AW-1:0]) >> blk_log2_reg;
        set32  = blk32 & ((32'd1 << sl_eff) - 32'd1);
        tag32  = blk32 >> sl_eff;
        in_set = set32[SET_W-1:0];
        in_tag = tag32[AW-1:0];
    end

    // Clear-pass sequencer
    cbp_pkg::state_t  state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clearing;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbp_pkg::ST_CLEAR: begin
                if (32'(clr_cnt_reg) == SETS - 1) begin
                    state_next = cbp_pkg::ST_RUN;
                end
            end
            cbp_pkg::ST_RUN: state_next = cbp_pkg::ST_RUN;
            default:         state_next = cbp_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        clearing     = 1'b0;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            cbp_pkg::ST_CLEAR: begin
                clearing     = 1'b1;
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
            end
            cbp_pkg::ST_RUN: clearing = 1'b0;
            default:         clearing = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cbp_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Handshake and stage control
    logic           s1_valid_reg, s1_fire, out_free, in_fire;
    logic           fwd_reg, fwd_next;
    cbp_pkg::mode_t s1_mode_reg;
    logic [SET_W-1:0] s1_set_reg;
    logic [AW-1:0]    s1_tag_reg;
    logic [ROW_W-1:0] fwd_row_reg, rd_row, cur_row, new_row;
    cbp_pkg::res_t    s1_res, res_reg;
    logic             m_valid_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_tready = !clearing && (!s1_valid_reg || out_free);
    assign in_fire  = s_tvalid && s_tready;
    assign fwd_next = s1_fire && (s1_set_reg == in_set);

    // Set row memory
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;

    always_comb begin
        ram_we    = clearing || s1_fire;
        ram_waddr = clearing ? clr_cnt_reg : s1_set_reg;
        ram_wdata = clearing ? '0 : new_row;
    end

    cbp_tag_ram #(
        .DEPTH  (SETS),
        .IDX_W  (SET_W),
        .DATA_W (ROW_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (in_set),
        .rdata (rd_row)
    );

    // Compare stage: forwarded row wins over a stale read
    assign cur_row = fwd_reg ? fwd_row_reg : rd_row;

    cbp_way_logic #(
        .WAYS  (WAYS),
        .TAG_W (AW),
        .NW_W  (NW_W)
    ) u_way (
        .row_in  (cur_row),
        .mode    (s1_mode_reg),
        .tag     (s1_tag_reg),
        .nw      (nw),
        .row_out (new_row),
        .res     (s1_res)
    );

    // Stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else if (in_fire) begin
            s1_valid_reg <= 1'b1;
            fwd_reg      <= fwd_next;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_mode_reg <= cbp_pkg::mode_t'(s_tuser);
            s1_set_reg  <= in_set;
            s1_tag_reg  <= in_tag;
            fwd_row_reg <= new_row;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            res_reg <= s1_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = cbp_pkg::OUT_DATA_W'(res_reg);

    // Checks
    logic s1_fill_fire;
    assign s1_fill_fire = s1_fire && (s1_mode_reg == cbp_pkg::MODE_FILL);

    `CBP_ASSERT_IMPL(a_no_accept_in_clear, aclk, aresetn, clearing, !s_tready, "accept in clear")
    `CBP_ASSERT_IMPL(a_fwd_needs_stage, aclk, aresetn, fwd_reg, s1_valid_reg, "stray fwd")
    `CBP_ASSERT_NEXT(a_fire_to_out, aclk, aresetn, s1_fire, m_valid_reg, "result lost")
    `CBP_ASSERT_NEXT(a_fill_no_hit, aclk, aresetn, s1_fill_fire, !res_reg.hit, "fill hit")

endmodule

`default_nettype wire
